@@ src/assert_macros.svh @@
// Assertion helpers for the packet receiver.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Concurrent check, sampled on clk, held off while rst is high.
`define FNPR_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Implication check: when ante holds, cons must hold in the same cycle.
`define FNPR_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`else

`define FNPR_ASSERT(lbl, clk, rst, prop, msg)
`define FNPR_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg)

`endif

`endif

@@ src/fnpr_pkg.sv @@
package fnpr_pkg;

  // Register indexes on the configuration port
  typedef enum logic [1:0] {
    CFG_SYNC_BYTE = 2'd0,
    CFG_BASE_KEY  = 2'd1,
    CFG_ACK_CODE  = 2'd2,
    CFG_NACK_CODE = 2'd3
  } cfg_index_t;

  // Position of the next byte inside a frame (after the start marker)
  typedef enum logic [1:0] {
    POS_NOTE = 2'd0,
    POS_DUR  = 2'd1,
    POS_SEQ  = 2'd2,
    POS_CHK  = 2'd3
  } frame_pos_t;

  typedef struct packed {
    logic [7:0] sync_byte;
    logic [7:0] base_key;
    logic [7:0] ack_code;
    logic [7:0] nack_code;
  } cfg_t;

  // Completed frame handed from the framer to the resolver
  typedef struct packed {
    logic [7:0] note;
    logic [7:0] dur;
    logic [7:0] seq;
    logic       chk_ok;
  } pkt_t;

  localparam int unsigned TABLE_SIZE = 21;

  // Chromatic table, C4 up to G#5
  function automatic logic [9:0] tone_lookup(input logic [4:0] idx);
    logic [9:0] hz;
    case (idx)
      5'd0:    hz = 10'd262;
      5'd1:    hz = 10'd277;
      5'd2:    hz = 10'd294;
      5'd3:    hz = 10'd311;
      5'd4:    hz = 10'd330;
      5'd5:    hz = 10'd349;
      5'd6:    hz = 10'd370;
      5'd7:    hz = 10'd392;
      5'd8:    hz = 10'd415;
      5'd9:    hz = 10'd440;
      5'd10:   hz = 10'd466;
      5'd11:   hz = 10'd494;
      5'd12:   hz = 10'd523;
      5'd13:   hz = 10'd554;
      5'd14:   hz = 10'd587;
      5'd15:   hz = 10'd622;
      5'd16:   hz = 10'd659;
      5'd17:   hz = 10'd698;
      5'd18:   hz = 10'd740;
      5'd19:   hz = 10'd784;
      5'd20:   hz = 10'd831;
      default: hz = 10'd0;
    endcase
    return hz;
  endfunction

endpackage

@@ src/fnpr_byte_if.sv @@
interface fnpr_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

@@ src/fnpr_result_if.sv @@
interface fnpr_result_if;
  logic        valid;
  logic        ready;
  logic [7:0]  reply_byte;
  logic        checksum_ok;
  logic        note_ok;
  logic [4:0]  note_number;
  logic [9:0]  tone_hz;
  logic [11:0] length_ms;
  logic [7:0]  sequence_res;

  modport source (
    output valid, output reply_byte, output checksum_ok, output note_ok,
    output note_number, output tone_hz, output length_ms, output sequence_res,
    input ready
  );
  modport sink (
    input valid, input reply_byte, input checksum_ok, input note_ok,
    input note_number, input tone_hz, input length_ms, input sequence_res,
    output ready
  );
endinterface

@@ src/fnpr_framer.sv @@
module fnpr_framer (
  input  logic                clk,
  input  logic                rst,
  fnpr_byte_if.sink           rx,
  input  logic [7:0]          sync_byte,
  output logic                pkt_valid,
  input  logic                pkt_ready,
  output fnpr_pkg::pkt_t      pkt
);

  logic                 in_frame;
  logic                 in_frame_next;
  fnpr_pkg::frame_pos_t pos;
  fnpr_pkg::frame_pos_t pos_next;
  logic [7:0]           running_xor;
  logic [7:0]           running_xor_next;
  logic [7:0]           note_q;
  logic [7:0]           dur_q;
  logic [7:0]           seq_q;
  logic                 pkt_valid_next;
  logic                 xfer;
  logic                 emit;

  // Slot frees up when the resolver takes the held packet
  assign rx.ready = !pkt_valid || pkt_ready;
  assign xfer     = rx.valid && rx.ready;
  assign emit     = xfer && in_frame && (pos == fnpr_pkg::POS_CHK);

  always_comb begin
    in_frame_next    = in_frame;
    pos_next         = pos;
    running_xor_next = running_xor;
    pkt_valid_next   = pkt_valid && !pkt_ready;
    if (xfer) begin
      if (!in_frame) begin
        if (rx.rx_byte == sync_byte) begin
          in_frame_next    = 1'b1;
          pos_next         = fnpr_pkg::POS_NOTE;
          running_xor_next = rx.rx_byte;
        end
      end else begin
        unique case (pos)
          fnpr_pkg::POS_NOTE: begin
            pos_next         = fnpr_pkg::POS_DUR;
            running_xor_next = running_xor ^ rx.rx_byte;
          end
          fnpr_pkg::POS_DUR: begin
            pos_next         = fnpr_pkg::POS_SEQ;
            running_xor_next = running_xor ^ rx.rx_byte;
          end
          fnpr_pkg::POS_SEQ: begin
            pos_next         = fnpr_pkg::POS_CHK;
            running_xor_next = running_xor ^ rx.rx_byte;
          end
          fnpr_pkg::POS_CHK: begin
            in_frame_next    = 1'b0;
            pos_next         = fnpr_pkg::POS_NOTE;
            running_xor_next = 8'd0;
            pkt_valid_next   = 1'b1;
          end
          default: begin
            in_frame_next    = 1'b0;
            pos_next         = fnpr_pkg::POS_NOTE;
            running_xor_next = 8'd0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame    <= 1'b0;
      pos         <= fnpr_pkg::POS_NOTE;
      running_xor <= 8'd0;
      pkt_valid   <= 1'b0;
    end else begin
      in_frame    <= in_frame_next;
      pos         <= pos_next;
      running_xor <= running_xor_next;
      pkt_valid   <= pkt_valid_next;
    end
  end

  // Frame payload bytes
  always_ff @(posedge clk) begin
    if (xfer && in_frame) begin
      if (pos == fnpr_pkg::POS_NOTE) note_q <= rx.rx_byte;
      if (pos == fnpr_pkg::POS_DUR)  dur_q  <= rx.rx_byte;
      if (pos == fnpr_pkg::POS_SEQ)  seq_q  <= rx.rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      pkt.note   <= note_q;
      pkt.dur    <= dur_q;
      pkt.seq    <= seq_q;
      pkt.chk_ok <= (running_xor == rx.rx_byte);
    end
  end

endmodule

@@ src/fnpr_resolver.sv @@
module fnpr_resolver #(
  parameter int unsigned NOTE_COUNT = 21
) (
  input  logic           clk,
  input  logic           rst,
  input  fnpr_pkg::cfg_t cfg,
  input  logic           pkt_valid,
  output logic           pkt_ready,
  input  fnpr_pkg::pkt_t pkt,
  fnpr_result_if.source  result
);

  logic [7:0]  key;
  logic [7:0]  note;
  logic [7:0]  dur;
  logic        nt_ok;
  logic [11:0] dur_x10;
  logic        load;

  assign pkt_ready = !result.valid || result.ready;
  assign load      = pkt_valid && pkt_ready;

  assign key     = cfg.base_key ^ pkt.seq;
  assign note    = pkt.note ^ key;
  assign dur     = pkt.dur ^ key;
  assign nt_ok   = pkt.chk_ok && (note < 8'(NOTE_COUNT)) &&
                   (note < 8'(fnpr_pkg::TABLE_SIZE));
  // dur * 10 as (dur << 3) + (dur << 1)
  assign dur_x10 = {1'b0, dur, 3'b000} + {3'b000, dur, 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (load) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result.reply_byte   <= pkt.chk_ok ? cfg.ack_code : cfg.nack_code;
      result.checksum_ok  <= pkt.chk_ok;
      result.note_ok      <= nt_ok;
      result.note_number  <= nt_ok ? note[4:0] : 5'd0;
      result.tone_hz      <= nt_ok ? fnpr_pkg::tone_lookup(note[4:0]) : 10'd0;
      result.length_ms    <= nt_ok ? dur_x10 : 12'd0;
      result.sequence_res <= pkt.seq;
    end
  end

endmodule

@@ src/framed_note_packet_receiver_unit.sv @@
// Framed note packet receiver. Takes one byte per cycle on rx while
// rx.ready is high; bytes are dropped until the sync byte arrives, then
// note, duration, sequence and checksum are collected. The checksum byte
// yields one result on result: ack/nack reply, and, on a good checksum with
// an in-range note, the decrypted note, its tone in Hz and the duration in
// ms. Throughput is one byte per clock while rx is not stalled; after its
// checksum byte transfers, a result passes through the framer packet
// register, then the resolver result register. While one result waits, rx
// keeps flowing; it stalls only once a second completed packet sits behind
// the waiting result. Configuration writes are registered.
`include "assert_macros.svh"

module framed_note_packet_receiver_unit #(
  parameter int unsigned NOTE_COUNT = 21
) (
  input  logic        clk,
  input  logic        rst,
  fnpr_byte_if.sink   rx,
  fnpr_result_if.source result,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_wdata
);

  fnpr_pkg::cfg_t cfg;
  logic           pkt_valid;
  logic           pkt_ready;
  fnpr_pkg::pkt_t pkt;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      unique case (fnpr_pkg::cfg_index_t'(cfg_index))
        fnpr_pkg::CFG_SYNC_BYTE: cfg.sync_byte <= cfg_wdata;
        fnpr_pkg::CFG_BASE_KEY:  cfg.base_key  <= cfg_wdata;
        fnpr_pkg::CFG_ACK_CODE:  cfg.ack_code  <= cfg_wdata;
        fnpr_pkg::CFG_NACK_CODE: cfg.nack_code <= cfg_wdata;
        default: ;
      endcase
    end
  end

  fnpr_framer u_framer (
    .clk       (clk),
    .rst       (rst),
    .rx        (rx),
    .sync_byte (cfg.sync_byte),
    .pkt_valid (pkt_valid),
    .pkt_ready (pkt_ready),
    .pkt       (pkt)
  );

  fnpr_resolver #(
    .NOTE_COUNT (NOTE_COUNT)
  ) u_resolver (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .pkt_valid (pkt_valid),
    .pkt_ready (pkt_ready),
    .pkt       (pkt),
    .result    (result)
  );

  `FNPR_ASSERT_IMPL(a_note_needs_chk, clk, rst, result.valid && result.note_ok,
    result.checksum_ok && (result.reply_byte == cfg.ack_code),
    "note_ok without good checksum or ack")
  `FNPR_ASSERT_IMPL(a_bad_note_zeroed, clk, rst, result.valid && !result.note_ok,
    (result.note_number == 5'd0) && (result.tone_hz == 10'd0) &&
    (result.length_ms == 12'd0), "invalid note fields not zero")
  `FNPR_ASSERT_IMPL(a_note_in_range, clk, rst, result.valid && result.note_ok,
    (result.note_number < 5'(NOTE_COUNT)) && (result.tone_hz != 10'd0),
    "note index out of range")
  `FNPR_ASSERT_IMPL(a_pkt_backpressure, clk, rst, pkt_valid && !pkt_ready, !rx.ready,
    "byte taken while packet slot full")

endmodule
